>>> hw/rtl/music_crossfade_duck_gain_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the music crossfade and ducking gain unit
// Clocked, reset-qualified property checks used by the checker module.
// ---------------------------------------------------------------------------
`ifndef MUSIC_CROSSFADE_DUCK_GAIN_UNIT_MACROS_SVH
`define MUSIC_CROSSFADE_DUCK_GAIN_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define MCDG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the next cycle
`define MCDG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mcdg_pkg.sv
// ---------------------------------------------------------------------------
// mcdg_pkg
// Shared types, constants and helpers of the music crossfade and ducking
// gain unit.
// ---------------------------------------------------------------------------
package mcdg_pkg;

  // Track numbering
  localparam int unsigned NUM_TRACKS = 16;
  localparam int unsigned TRACK_W    = $clog2(NUM_TRACKS + 1);
  localparam int unsigned REQ_W      = 4;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned MASK_IDX_W = $clog2(MASK_W);
  localparam logic [TRACK_W-1:0] TRACK_NONE = TRACK_W'(NUM_TRACKS);

  // Q16 gain arithmetic
  localparam int unsigned GAIN_W   = 17;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = 2 * GAIN_W;
  localparam logic [GAIN_W-1:0] UNITY    = 17'd65536;
  localparam logic [GAIN_W-1:0] DUCK_LOW = 17'd22938;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  // Timing fields
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned STEP_W    = ELAPSED_W + 3;
  localparam int unsigned FADE_W    = 21;
  localparam logic [FADE_W-1:0] FADE_MAX = {FADE_W{1'b1}};
  localparam int unsigned DIV_CNT_W = $clog2(FRAC_W + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MUSIC_VOLUME = 3'd0,
    CFG_MUTE         = 3'd1,
    CFG_DUCK_ENABLE  = 3'd2,
    CFG_FADE_LENGTH  = 3'd3,
    CFG_TRACK_MASK   = 3'd4,
    CFG_DEVICE_READY = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_PLAY      = 2'd1,
    CMD_VOICE_ON  = 2'd2,
    CMD_VOICE_OFF = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BASE,
    ST_DIV_START,
    ST_DIV,
    ST_CUR,
    ST_PREV,
    ST_DONE
  } state_e;

  // Status of the fraction divider
  typedef struct packed {
    logic              busy;
    logic [FRAC_W-1:0] quo;
  } div_stat_t;

  // A track is valid when in range and its present bit is set
  function automatic logic track_valid(input logic [TRACK_W-1:0] t,
                                       input logic [MASK_W-1:0]  mask);
    logic ok;
    ok = 1'b0;
    if (t < TRACK_W'(NUM_TRACKS) && t < TRACK_W'(MASK_W)) begin
      ok = mask[t[MASK_IDX_W-1:0]];
    end
    return ok;
  endfunction

  // Round a Q16 x Q16 product half up back to Q16
  function automatic logic [GAIN_W-1:0] q16_round(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + ROUND_HALF;
    return s[FRAC_W +: GAIN_W];
  endfunction

endpackage

>>> hw/rtl/mcdg_frac_div.sv
// ---------------------------------------------------------------------------
// mcdg_frac_div
// Bit-serial restoring divider for the crossfade fraction:
// quo = floor(num * 2^16 / den), one quotient bit per cycle, num < den.
// ---------------------------------------------------------------------------
module mcdg_frac_div
  import mcdg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FADE_W-1:0] num_i,
  input  logic [FADE_W-1:0] den_i,
  output div_stat_t         stat_o
);

  logic [FADE_W-1:0]    rem_q, rem_d;
  logic [FRAC_W-1:0]    quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [FADE_W:0]      rem_sh;
  logic [FADE_W:0]      rem_sub;
  logic                 fits;

  // Shift in one zero bit and try to subtract the divisor
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_i};
  assign fits    = rem_sh >= {1'b0, den_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = num_i;
      quo_d = '0;
      cnt_d = DIV_CNT_W'(FRAC_W);
    end else if (cnt_q != '0) begin
      rem_d = fits ? rem_sub[FADE_W-1:0] : rem_sh[FADE_W-1:0];
      quo_d = {quo_q[FRAC_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
    end
  end

  // Hold the iteration count under reset, the datapath needs none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = cnt_q != '0;
  assign stat_o.quo  = quo_q;

endmodule

>>> hw/rtl/music_crossfade_duck_gain_unit.sv
// ---------------------------------------------------------------------------
// music_crossfade_duck_gain_unit
// Background music gain controller: tracks the current and fading-out track,
// runs a linear crossfade and a ducking ramp, and reports Q16 track gains.
//
//   channel   dir  fields (lowest bit first)
//   s_axis    in   tuser: command[1:0]; tdata: elapsed[15:0], track[19:16]
//   m_axis    out  tdata: current_track, current_gain, previous_track,
//                  previous_gain, start_current, stop_previous, fading
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Each item runs through a state update, the base gain product, the
// bit-serial fraction divider (the load, then 16 quotient bits), two more
// products on the one shared 17x17 multiplier, and the output load; the
// sequencer returns to idle before it accepts the next beat. A finished
// result sits in the output register, so the next beat is taken while it
// waits; a stalled output holds the sequencer in its last step only when a
// second result is ready. Reset is asynchronous.
// ---------------------------------------------------------------------------
module music_crossfade_duck_gain_unit
  import mcdg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // elapsed[15:0], track[19:16], zero
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // command[1:0]
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // current_track[4:0],
                                               // current_gain[21:5],
                                               // previous_track[26:22],
                                               // previous_gain[43:27],
                                               // start_current[44],
                                               // stop_previous[45], fading[46]
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [GAIN_W-1:0]  volume_q;
  logic               mute_q;
  logic               duck_en_q;
  logic [FADE_W-1:0]  fade_len_q;
  logic [MASK_W-1:0]  mask_q;
  logic               ready_q;

  // Block state
  logic [TRACK_W-1:0] now_q, now_d;
  logic [TRACK_W-1:0] old_q, old_d;
  logic               xfade_q, xfade_d;
  logic [FADE_W-1:0]  fade_el_q, fade_el_d;
  logic [GAIN_W-1:0]  duck_q, duck_d;
  logic [GAIN_W-1:0]  goal_q, goal_d;
  logic               voice_q, voice_d;

  // Captured beat
  cmd_e               cmd_q;
  logic [ELAPSED_W-1:0] el_q;
  logic [REQ_W-1:0]   trk_q;

  // Per-item results of the state update
  logic [TRACK_W-1:0] rep_prev_q, rep_prev_d;
  logic               start_q, start_d;
  logic               stop_q, stop_d;
  logic               cur_ok_q, cur_ok_d;
  logic               prev_ok_q, prev_ok_d;
  logic               xf_calc_q, xf_calc_d;

  // Datapath registers
  logic [PROD_W-1:0]  prod_q;
  logic [GAIN_W-1:0]  base_q;
  logic [GAIN_W-1:0]  frac_q;
  logic [GAIN_W-1:0]  cur_g_q;

  // Sequencer and its controls
  state_e             state_q, state_d;
  logic               exec_en, base_ld, div_start, frac_ld, cur_ld, out_ld;
  logic               sel_frac, sel_inv;
  logic               slot_free;

  // Output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Combinational helpers
  logic [STEP_W-1:0]  step;
  logic [GAIN_W-1:0]  gap;
  logic [FADE_W:0]    fade_sum;
  logic [FADE_W-1:0]  fade_new;
  logic [GAIN_W-1:0]  vol_clamp;
  logic [GAIN_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  prod_d;
  logic               frac_sat;
  logic [GAIN_W-1:0]  cur_gain, prev_gain;
  div_stat_t          div_stat;

  logic [TRACK_W-1:0] req_trk;
  assign req_trk = TRACK_W'(trk_q);

  // ---------------- Configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q   <= UNITY;
      mute_q     <= 1'b0;
      duck_en_q  <= 1'b1;
      fade_len_q <= FADE_W'(65536);
      mask_q     <= '1;
      ready_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MUSIC_VOLUME: volume_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_MUTE:         mute_q     <= cfg_data_i[0];
        CFG_DUCK_ENABLE:  duck_en_q  <= cfg_data_i[0];
        CFG_FADE_LENGTH:  fade_len_q <= cfg_data_i[FADE_W-1:0];
        CFG_TRACK_MASK:   mask_q     <= cfg_data_i[MASK_W-1:0];
        CFG_DEVICE_READY: ready_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- Command execution ----------------
  // Duck step is elapsed * 6
  assign step     = {1'b0, el_q, 2'b00} + {2'b00, el_q, 1'b0};
  assign gap      = (duck_q < goal_q) ? (goal_q - duck_q) : (duck_q - goal_q);
  assign fade_sum = {1'b0, fade_el_q} + (FADE_W + 1)'(el_q);
  assign fade_new = fade_sum[FADE_W] ? FADE_MAX : fade_sum[FADE_W-1:0];

  always_comb begin
    logic ended;
    now_d      = now_q;
    old_d      = old_q;
    xfade_d    = xfade_q;
    fade_el_d  = fade_el_q;
    duck_d     = duck_q;
    goal_d     = goal_q;
    voice_d    = voice_q;
    start_d    = 1'b0;
    stop_d     = 1'b0;
    ended      = 1'b0;

    unique case (cmd_q)
      CMD_TICK: begin
        if (ready_q) begin
          // Ramp the duck gain toward its goal, landing exactly on it
          if (duck_q != goal_q) begin
            if (STEP_W'(gap) <= step) begin
              duck_d = goal_q;
            end else if (duck_q < goal_q) begin
              duck_d = duck_q + step[GAIN_W-1:0];
            end else begin
              duck_d = duck_q - step[GAIN_W-1:0];
            end
          end
          // Advance the fade timer and detect its end
          if (xfade_q) begin
            fade_el_d = fade_new;
            ended     = (fade_len_q == '0) || (fade_new >= fade_len_q);
          end
        end
      end
      CMD_PLAY: begin
        if (req_trk < TRACK_W'(NUM_TRACKS) && req_trk != now_q) begin
          if (!ready_q) begin
            now_d = req_trk;
          end else begin
            stop_d    = xfade_q && track_valid(old_q, mask_q);
            old_d     = now_q;
            now_d     = req_trk;
            xfade_d   = now_q != TRACK_NONE;
            fade_el_d = '0;
            start_d   = track_valid(req_trk, mask_q);
          end
        end
      end
      CMD_VOICE_ON: begin
        if (ready_q) begin
          voice_d = 1'b1;
          goal_d  = duck_en_q ? DUCK_LOW : UNITY;
        end
      end
      CMD_VOICE_OFF: begin
        if (ready_q && voice_q) begin
          voice_d = 1'b0;
          goal_d  = UNITY;
        end
      end
      default: ;
    endcase

    // Gains are judged on the state after the command
    rep_prev_d = old_d;
    cur_ok_d   = ready_q && track_valid(now_d, mask_q);
    prev_ok_d  = ready_q && xfade_d && track_valid(old_d, mask_q);
    xf_calc_d  = xfade_d;

    // Drop the faded-out track at the end of the crossfade
    if (ended) begin
      stop_d    = stop_d || track_valid(old_d, mask_q);
      prev_ok_d = 1'b0;
      old_d     = TRACK_NONE;
      xfade_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= TRACK_NONE;
      old_q     <= TRACK_NONE;
      xfade_q   <= 1'b0;
      fade_el_q <= '0;
      duck_q    <= UNITY;
      goal_q    <= UNITY;
      voice_q   <= 1'b0;
    end else if (exec_en) begin
      now_q     <= now_d;
      old_q     <= old_d;
      xfade_q   <= xfade_d;
      fade_el_q <= fade_el_d;
      duck_q    <= duck_d;
      goal_q    <= goal_d;
      voice_q   <= voice_d;
    end
  end

  // Capture the beat and the per-item flags
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= cmd_e'(s_axis_tuser[1:0]);
      el_q  <= s_axis_tdata[ELAPSED_W-1:0];
      trk_q <= s_axis_tdata[ELAPSED_W +: REQ_W];
    end
    if (exec_en) begin
      rep_prev_q <= rep_prev_d;
      start_q    <= start_d;
      stop_q     <= stop_d;
      cur_ok_q   <= cur_ok_d;
      prev_ok_q  <= prev_ok_d;
      xf_calc_q  <= xf_calc_d;
    end
  end

  // ---------------- Shared multiplier ----------------
  assign vol_clamp = (volume_q > UNITY) ? UNITY : volume_q;

  always_comb begin
    mul_a = vol_clamp;
    mul_b = duck_q;
    if (sel_frac) begin
      mul_a = base_q;
      mul_b = frac_q;
    end else if (sel_inv) begin
      mul_a = base_q;
      mul_b = UNITY - frac_q;
    end
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // ---------------- Fraction divider ----------------
  mcdg_frac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (fade_el_q),
    .den_i   (fade_len_q),
    .stat_o  (div_stat)
  );

  assign frac_sat = (fade_len_q == '0) || (fade_el_q >= fade_len_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (base_ld) begin
      base_q <= mute_q ? '0 : q16_round(prod_q);
    end
    if (frac_ld) begin
      frac_q <= frac_sat ? UNITY : GAIN_W'(div_stat.quo);
    end
    if (cur_ld) begin
      cur_g_q <= q16_round(prod_q);
    end
  end

  // ---------------- Result assembly ----------------
  assign cur_gain  = !cur_ok_q ? '0 : (xf_calc_q ? cur_g_q : base_q);
  assign prev_gain = prev_ok_q ? q16_round(prod_q) : '0;
  assign slot_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_data_q <= {1'b0, xfade_q, stop_q, start_q, prev_gain, rep_prev_q,
                     cur_gain, now_q};
    end
  end

  // ---------------- Sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (s_axis_tvalid) state_d = ST_EXEC;
      ST_EXEC:      state_d = ST_BASE;
      ST_BASE:      state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV:       if (!div_stat.busy) state_d = ST_CUR;
      ST_CUR:       state_d = ST_PREV;
      ST_PREV:      state_d = ST_DONE;
      ST_DONE:      if (slot_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    exec_en   = 1'b0;
    base_ld   = 1'b0;
    div_start = 1'b0;
    frac_ld   = 1'b0;
    cur_ld    = 1'b0;
    out_ld    = 1'b0;
    sel_frac  = 1'b0;
    sel_inv   = 1'b0;
    unique case (state_q)
      ST_EXEC:      exec_en = 1'b1;
      ST_DIV_START: begin
        base_ld   = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV:       frac_ld = !div_stat.busy;
      ST_CUR:       sel_frac = 1'b1;
      ST_PREV: begin
        cur_ld  = 1'b1;
        sel_inv = 1'b1;
      end
      // Keep the previous-gain product in place while the result waits
      ST_DONE: begin
        out_ld  = slot_free;
        sel_inv = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hw/rtl/mcdg_checker.sv
// ---------------------------------------------------------------------------
// mcdg_checker
// Port-level checks of the music crossfade and ducking gain unit, bound to
// the top level.
// ---------------------------------------------------------------------------
`include "music_crossfade_duck_gain_unit_macros.svh"

module mcdg_checker
  import mcdg_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [GAIN_W-1:0]  cur_gain, prev_gain;
  logic [TRACK_W-1:0] prev_trk;
  logic               fading;

  assign cur_gain  = m_axis_tdata[21:5];
  assign prev_trk  = m_axis_tdata[26:22];
  assign prev_gain = m_axis_tdata[43:27];
  assign fading    = m_axis_tdata[46];

  // A stalled result beat holds its contents
  `MCDG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // An accepted beat keeps the unit busy on the next cycle
  `MCDG_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again right after accept")

  // Gains never exceed unity
  `MCDG_ASSERT(a_gain_range, !m_axis_tvalid || (cur_gain <= UNITY && prev_gain <= UNITY), "gain above unity")

  // A crossfade always has a track fading out
  `MCDG_ASSERT(a_fade_has_prev, !(m_axis_tvalid && fading) || prev_trk != TRACK_NONE, "fading without previous track")

endmodule

bind music_crossfade_duck_gain_unit mcdg_checker u_mcdg_checker (.*);
